FILE: hw/rtl/wbss_pkg.sv
// Shared constants and types for the wildcard byte signature scanner.
package wbss_pkg;

   localparam int unsigned DEFAULT_MAX_PATTERN_BYTES = 16;
   localparam int unsigned PATTERN_BYTES_CAP         = 16;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned ADDR_W    = 64;
   localparam int unsigned CSR_W     = 64;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned LEN_W     = 5;
   localparam int unsigned PATTERN_W = PATTERN_BYTES_CAP * BYTE_W;

   localparam logic [BYTE_W-1:0] WILDCARD_BYTE = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2,
      CSR_BASE_ADDRESS   = 2'd3
   } csr_index_type;

endpackage

FILE: hw/rtl/wbss_if.sv
// Valid/ready stream interfaces for the scanner's byte and result channels.
interface wbss_req_if;
   logic                          valid;
   logic                          ready;
   logic [wbss_pkg::BYTE_W-1:0]   data_byte;
   logic                          start_scan;

   modport source (output valid, output data_byte, output start_scan, input ready);
   modport sink   (input valid, input data_byte, input start_scan, output ready);
endinterface

interface wbss_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wbss_pkg::ADDR_W-1:0]   match_address;

   modport source (output valid, output match_address, input ready);
   modport sink   (input valid, input match_address, output ready);
endinterface

FILE: hw/rtl/wbss_match.sv
// Parallel wildcard compare of the byte window against the pattern.
module wbss_match #(
   parameter int unsigned MAX_PATTERN_BYTES = wbss_pkg::DEFAULT_MAX_PATTERN_BYTES
) (
   input  logic [MAX_PATTERN_BYTES-1:0][wbss_pkg::BYTE_W-1:0] window,
   input  logic [wbss_pkg::PATTERN_W-1:0]                     pattern,
   input  logic [wbss_pkg::LEN_W-1:0]                         length,
   output logic                                               hit
);

   localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

   logic [MAX_PATTERN_BYTES-1:0] byte_ok;

   always_comb begin
      logic [wbss_pkg::LEN_W-1:0]  tap;
      logic [wbss_pkg::BYTE_W-1:0] pat;
      logic [wbss_pkg::BYTE_W-1:0] win;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         // pattern byte i lines up with the window entry length-1-i back
         tap = length - wbss_pkg::LEN_W'(1) - wbss_pkg::LEN_W'(i);
         pat = pattern[i*wbss_pkg::BYTE_W +: wbss_pkg::BYTE_W];
         win = window[tap[IDX_W-1:0]];
         if (wbss_pkg::LEN_W'(i) >= length) begin
            byte_ok[i] = 1'b1;
         end else begin
            byte_ok[i] = (pat == wbss_pkg::WILDCARD_BYTE) || (pat == win);
         end
      end
   end

   assign hit = &byte_ok;

endmodule

FILE: hw/rtl/wildcard_byte_signature_scan_top.sv
// Top level of the wildcard byte signature scanner.
// Takes one byte per cycle: req_bus.ready stays high unless a match address is waiting
// in the result register and rsp_bus.ready is low. Each accepted byte shifts into a
// window of MAX_PATTERN_BYTES entries, and the whole window is compared against the
// configured pattern (0xFF bytes are wildcards) in the same cycle, so a match address
// appears on rsp_bus in the cycle after the byte that completes it. Matches never overlap;
// the address is base_address plus the offset of the match's first byte, wrapping at
// 2^64. start_scan restarts the offset and the overlap tracking at that byte. Write
// registers through csr_* only while no byte is in flight.
module wildcard_byte_signature_scan_top #(
   parameter int unsigned MAX_PATTERN_BYTES = wbss_pkg::DEFAULT_MAX_PATTERN_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [wbss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wbss_pkg::CSR_W-1:0]       csr_data,
   wbss_req_if.sink                         req_bus,
   wbss_rsp_if.source                       rsp_bus
);

   localparam int unsigned CNT_W = $clog2(MAX_PATTERN_BYTES + 1);

   logic [wbss_pkg::CSR_W-1:0]   pattern_low_ff;
   logic [wbss_pkg::CSR_W-1:0]   pattern_high_ff;
   logic [wbss_pkg::LEN_W-1:0]   pattern_length_ff;
   logic [wbss_pkg::ADDR_W-1:0]  base_address_ff;

   logic [MAX_PATTERN_BYTES-1:0][wbss_pkg::BYTE_W-1:0] window_ff, window_in;
   logic [wbss_pkg::ADDR_W-1:0]  position_ff, position_in, position_cur;
   logic [CNT_W-1:0]             since_ff, since_in, since_cur;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [wbss_pkg::ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;

   logic                         accept;
   logic                         cmp_hit;
   logic                         hit;
   logic [wbss_pkg::LEN_W-1:0]   length_eff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= wbss_pkg::LEN_W'(1);
         base_address_ff   <= '0;
      end else if (csr_we) begin
         unique case (wbss_pkg::csr_index_type'(csr_index))
            wbss_pkg::CSR_PATTERN_LOW:    pattern_low_ff    <= csr_data;
            wbss_pkg::CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_data;
            wbss_pkg::CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[wbss_pkg::LEN_W-1:0];
            wbss_pkg::CSR_BASE_ADDRESS:   base_address_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // clamp length into 1..MAX_PATTERN_BYTES
   always_comb begin
      if (pattern_length_ff == '0) begin
         length_eff = wbss_pkg::LEN_W'(1);
      end else if (pattern_length_ff > wbss_pkg::LEN_W'(MAX_PATTERN_BYTES)) begin
         length_eff = wbss_pkg::LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         length_eff = pattern_length_ff;
      end
   end

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // window entries older than the scan start are never used: the since counter
   // keeps a match from reaching past them, so start needs no window clear
   always_comb begin
      window_in[0] = req_bus.data_byte;
      for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   always_comb begin
      position_cur = req_bus.start_scan ? '0 : position_ff;
      since_cur    = req_bus.start_scan ? '0 : since_ff;
      if (since_cur < CNT_W'(MAX_PATTERN_BYTES)) begin
         since_cur = since_cur + CNT_W'(1);
      end
   end

   wbss_match #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_match (
      .window  (window_in),
      .pattern ({pattern_high_ff, pattern_low_ff}),
      .length  (length_eff),
      .hit     (cmp_hit)
   );

   assign hit = cmp_hit && (wbss_pkg::LEN_W'(since_cur) >= length_eff);

   always_comb begin
      position_in  = position_ff;
      since_in     = since_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (accept) begin
         position_in = position_cur + wbss_pkg::ADDR_W'(1);
         since_in    = hit ? '0 : since_cur;
         if (hit) begin
            rsp_valid_in = 1'b1;
            rsp_addr_in  = base_address_ff + position_cur
                         - wbss_pkg::ADDR_W'(length_eff - wbss_pkg::LEN_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         since_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         position_ff  <= position_in;
         since_ff     <= since_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
      rsp_addr_ff <= rsp_addr_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.match_address = rsp_addr_ff;

endmodule
